@@ rtl/bpc_pkg.sv @@
`default_nettype none

package bpc_pkg;

    // configuration register indexes
    localparam int CfgIdxWidth = 2;
    localparam logic [CfgIdxWidth-1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_LONG_PRESS = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_DOUBLE_MAX = 2'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_SHORT_WAIT = 2'd3;

    localparam int CfgDataWidth = 16;
    localparam int TimeWidth    = 32;

    // register reset values in milliseconds
    localparam logic [CfgDataWidth-1:0] DEBOUNCE_RST   = 16'd20;
    localparam logic [CfgDataWidth-1:0] LONG_PRESS_RST = 16'd2000;
    localparam logic [CfgDataWidth-1:0] DOUBLE_MAX_RST = 16'd600;
    localparam logic [CfgDataWidth-1:0] SHORT_WAIT_RST = 16'd350;

    // press event codes
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SHORT  = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } press_event_t;

    // one poll
    typedef struct packed {
        logic                 raw_pressed;
        logic [TimeWidth-1:0] now_ms;
    } in_item_t;

    // one classification result
    typedef struct packed {
        press_event_t press_event;
        logic         held;
    } out_item_t;

endpackage

`default_nettype wire

@@ rtl/button_press_classifier.sv @@
`default_nettype none

// channel   direction  ports                       payload
// poll      in         s_valid s_ready s_item      raw_pressed, now_ms
// result    out        m_valid m_ready m_item      press_event, held
// config    in         cfg_we cfg_index cfg_data   debounce/long/double/short ms
//
// one result per poll, via the poll register and then the result register; one poll per cycle
// sustained unless the result stalls, set by the single classify step between the two registers
// aresetn is synchronous, active low: clears both valid flags, the button state
// and loads the default timings
// a stalled result register holds the poll register; a new poll is taken whenever
// the poll register is empty or moves on in the same cycle
module button_press_classifier
    import bpc_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,

    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire in_item_t                s_item,

    output logic                         m_valid,
    input  wire logic                    m_ready,
    output out_item_t                    m_item,

    input  wire logic                    cfg_we,
    input  wire logic [CfgIdxWidth-1:0]  cfg_index,
    input  wire logic [CfgDataWidth-1:0] cfg_data
);

    // configuration registers
    logic [CfgDataWidth-1:0] debounce_ms_reg;
    logic [CfgDataWidth-1:0] long_press_ms_reg;
    logic [CfgDataWidth-1:0] double_max_ms_reg;
    logic [CfgDataWidth-1:0] short_wait_ms_reg;

    // poll register and result register
    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t out_item_next;

    // classifier state
    logic                 stable_level_reg,   stable_level_next;
    logic [TimeWidth-1:0] debounce_start_reg, debounce_start_next;
    logic [TimeWidth-1:0] press_time_reg,     press_time_next;
    logic [TimeWidth-1:0] release_time_reg,   release_time_next;
    logic                 long_reported_reg,  long_reported_next;
    logic                 short_pending_reg,  short_pending_next;

    logic advance;

    // handshake
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_ms_reg   <= DEBOUNCE_RST;
            long_press_ms_reg <= LONG_PRESS_RST;
            double_max_ms_reg <= DOUBLE_MAX_RST;
            short_wait_ms_reg <= SHORT_WAIT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_DEBOUNCE:   debounce_ms_reg   <= cfg_data;
                CFG_LONG_PRESS: long_press_ms_reg <= cfg_data;
                CFG_DOUBLE_MAX: double_max_ms_reg <= cfg_data;
                CFG_SHORT_WAIT: short_wait_ms_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // classify one poll
    always_comb begin
        logic                 raw;
        logic [TimeWidth-1:0] now;
        logic                 mismatch;
        logic [TimeWidth-1:0] start_eff;
        logic [TimeWidth-1:0] deb_diff;
        logic                 deb_ok;
        logic [TimeWidth-1:0] press_diff;
        logic [TimeWidth-1:0] rel_diff;
        logic                 done;
        press_event_t         ev;

        raw       = in_item_reg.raw_pressed;
        now       = in_item_reg.now_ms;
        mismatch  = raw != stable_level_reg;
        start_eff = (debounce_start_reg == '0) ? now : debounce_start_reg;
        deb_diff  = now - start_eff;
        deb_ok    = mismatch && (deb_diff >= {{(TimeWidth-CfgDataWidth){1'b0}},
                                              debounce_ms_reg});
        press_diff = now - press_time_reg;
        rel_diff   = now - release_time_reg;

        stable_level_next   = deb_ok ? raw : stable_level_reg;
        debounce_start_next = (mismatch && !deb_ok) ? start_eff : '0;
        press_time_next     = (deb_ok && raw) ? now : press_time_reg;
        release_time_next   = (deb_ok && !raw) ? now : release_time_reg;
        long_reported_next  = (deb_ok && raw) ? 1'b0 : long_reported_reg;
        short_pending_next  = short_pending_reg;
        ev   = EV_NONE;
        done = 1'b0;

        // release edge: double press or start a pending short
        if (deb_ok && !raw && !long_reported_reg) begin
            if (short_pending_reg &&
                press_diff < {{(TimeWidth-CfgDataWidth){1'b0}}, double_max_ms_reg}) begin
                short_pending_next = 1'b0;
                ev   = EV_DOUBLE;
                done = 1'b1;
            end else begin
                short_pending_next = 1'b1;
            end
        end

        // a fresh edge restarts its own timer at zero
        if (deb_ok && raw) begin
            press_diff = '0;
        end
        if (deb_ok && !raw) begin
            rel_diff = '0;
        end

        // long hold, else confirmed short
        if (!done) begin
            if (stable_level_next && !long_reported_next &&
                press_diff >= {{(TimeWidth-CfgDataWidth){1'b0}}, long_press_ms_reg}) begin
                long_reported_next = 1'b1;
                short_pending_next = 1'b0;
                ev = EV_LONG;
            end else if (!stable_level_next && short_pending_next &&
                rel_diff > {{(TimeWidth-CfgDataWidth){1'b0}}, short_wait_ms_reg}) begin
                short_pending_next = 1'b0;
                ev = EV_SHORT;
            end
        end

        out_item_next.press_event = ev;
        out_item_next.held        = stable_level_next;
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            stable_level_reg   <= 1'b0;
            debounce_start_reg <= '0;
            press_time_reg     <= '0;
            release_time_reg   <= '0;
            long_reported_reg  <= 1'b0;
            short_pending_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg      <= 1'b1;
                stable_level_reg   <= stable_level_next;
                debounce_start_reg <= debounce_start_next;
                press_time_reg     <= press_time_next;
                release_time_reg   <= release_time_next;
                long_reported_reg  <= long_reported_next;
                short_pending_reg  <= short_pending_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_item_reg <= out_item_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/bpc_checker.sv @@
`default_nettype none

module bpc_checker
    import bpc_pkg::*;
(
    input wire logic                    aclk,
    input wire logic                    aresetn,
    input wire logic                    m_valid,
    input wire logic                    m_ready,
    input wire out_item_t               m_item
);

    // result stays put while stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
    else $error("result changed while stalled");

    // reset empties the result register
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
    else $error("result valid right after reset");

    // short and double presses are reported on a released button
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item.press_event == EV_SHORT || m_item.press_event == EV_DOUBLE)
        |-> !m_item.held)
    else $error("short or double press while held");

    // long press is reported on a held button
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.press_event == EV_LONG |-> m_item.held)
    else $error("long press while released");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (.*);

`default_nettype wire
